### hw/rtl/kpsr_pkg.sv
`timescale 1ns / 1ps
// kpsr_pkg: types, codes and constants of the keypad stepper rate controller
// used by the control unit, the top level and the checker

package kpsr_pkg;

  localparam int MAX_DIGITS = 3;

  // item kinds
  typedef enum logic {
    ACT_KEY  = 1'b0,
    ACT_TICK = 1'b1
  } kpsr_action_e;

  // keypad codes, digits are 0 to 9
  typedef enum logic [3:0] {
    KEY_0    = 4'd0,
    KEY_1    = 4'd1,
    KEY_2    = 4'd2,
    KEY_3    = 4'd3,
    KEY_4    = 4'd4,
    KEY_5    = 4'd5,
    KEY_6    = 4'd6,
    KEY_7    = 4'd7,
    KEY_8    = 4'd8,
    KEY_9    = 4'd9,
    KEY_STAR = 4'd10,
    KEY_HASH = 4'd11,
    KEY_A    = 4'd12,
    KEY_B    = 4'd13,
    KEY_C    = 4'd14,
    KEY_D    = 4'd15
  } kpsr_key_e;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_CW   = 2'd1,
    MODE_ACW  = 2'd2
  } kpsr_mode_e;

  localparam logic [9:0]  SPEED_CAP    = 10'd300;
  localparam logic [8:0]  SPEED_MIN    = 9'd20;
  localparam logic [10:0] PERIOD_SLOW  = 11'd2000;
  localparam logic [10:0] PERIOD_RESET = 11'd1000;
  localparam logic [9:0]  DECIMAL_BASE = 10'd10;

  // (speed - 20) * 85 / 14 as one multiply by a scaled reciprocal;
  // exact for every speed offset up to 280
  localparam int          RECIP_SHIFT  = 12;
  localparam logic [14:0] RECIP_MULT   = 15'd24869;

  typedef struct packed {
    logic        step_level;
    logic        dir_level;
    logic        drive_on;
    kpsr_mode_e  run_mode;
    logic [8:0]  applied_speed;
    logic [10:0] half_period_us;
    logic [9:0]  pending_value;
    logic [1:0]  pending_digits;
    logic [31:0] steps_taken;
    logic [31:0] last_toggle_us;
  } kpsr_state_t;

  localparam kpsr_state_t STATE_RESET = '{
    step_level:     1'b0,
    dir_level:      1'b1,
    drive_on:       1'b0,
    run_mode:       MODE_STOP,
    applied_speed:  9'd0,
    half_period_us: PERIOD_RESET,
    pending_value:  10'd0,
    pending_digits: 2'd0,
    steps_taken:    32'd0,
    last_toggle_us: 32'd0
  };

  // half period for a speed between 20 and 300
  function automatic logic [10:0] half_period_f(input logic [8:0] speed);
    logic [8:0]  offs;
    logic [23:0] prod;
    offs = speed - SPEED_MIN;
    prod = 24'(offs) * 24'(RECIP_MULT);
    return PERIOD_SLOW - prod[RECIP_SHIFT +: 11];
  endfunction

endpackage

### hw/rtl/kpsr_if.sv
`timescale 1ns / 1ps
// kpsr_item_if and kpsr_result_if: valid/ready channels of the controller
// depends on nothing

interface kpsr_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  key_code;
  logic [31:0] now_us;

  modport source (output valid, action, key_code, now_us, input ready);
  modport sink   (input valid, action, key_code, now_us, output ready);
endinterface

interface kpsr_result_if;
  logic        valid;
  logic        ready;
  logic        step_level;
  logic        dir_level;
  logic        drive_on;
  logic [1:0]  run_mode;
  logic [8:0]  applied_speed;
  logic [10:0] half_period_us;
  logic [9:0]  pending_value;
  logic [1:0]  pending_digits;
  logic [31:0] steps_taken;

  modport source (output valid, step_level, dir_level, drive_on, run_mode, applied_speed,
                  half_period_us, pending_value, pending_digits, steps_taken,
                  input ready);
  modport sink   (input valid, step_level, dir_level, drive_on, run_mode, applied_speed,
                  half_period_us, pending_value, pending_digits, steps_taken,
                  output ready);
endinterface

### hw/rtl/kpsr_ctrl.sv
`timescale 1ns / 1ps
// kpsr_ctrl: controller state and its single-pass update per word
// depends on kpsr_pkg

module kpsr_ctrl #(
  parameter int MaxDigits = kpsr_pkg::MAX_DIGITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  action_i,
  input  logic [3:0]            key_i,
  input  logic [31:0]           now_i,
  output kpsr_pkg::kpsr_state_t state_o
);

  kpsr_pkg::kpsr_state_t st_q, st_d;

  logic [8:0]  clamped;
  logic [31:0] elapsed;
  logic [13:0] shifted;

  assign clamped = (st_q.pending_value > kpsr_pkg::SPEED_CAP)
                   ? kpsr_pkg::SPEED_CAP[8:0] : st_q.pending_value[8:0];
  assign elapsed = now_i - st_q.last_toggle_us;
  assign shifted = 14'(st_q.pending_value) * 14'(kpsr_pkg::DECIMAL_BASE) + 14'(key_i);

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      if (action_i == kpsr_pkg::ACT_TICK) begin
        if (st_q.drive_on && (elapsed >= 32'(st_q.half_period_us))) begin
          st_d.last_toggle_us = now_i;
          st_d.step_level     = ~st_q.step_level;
          if (!st_q.step_level) begin
            st_d.steps_taken = st_q.steps_taken + 32'd1;
          end
        end
      end else if (key_i <= kpsr_pkg::KEY_9) begin
        // digit ignored once the entry is full
        if (st_q.pending_digits < 2'(MaxDigits)) begin
          st_d.pending_value  = shifted[9:0];
          st_d.pending_digits = st_q.pending_digits + 2'd1;
        end
      end else begin
        case (kpsr_pkg::kpsr_key_e'(key_i))
          kpsr_pkg::KEY_STAR, kpsr_pkg::KEY_HASH: begin
            st_d.dir_level      = (key_i == kpsr_pkg::KEY_STAR);
            st_d.applied_speed  = clamped;
            st_d.pending_value  = '0;
            st_d.pending_digits = '0;
            if (clamped < kpsr_pkg::SPEED_MIN) begin
              st_d.run_mode = kpsr_pkg::MODE_STOP;
              st_d.drive_on = 1'b0;
            end else begin
              st_d.run_mode       = (key_i == kpsr_pkg::KEY_STAR)
                                    ? kpsr_pkg::MODE_CW : kpsr_pkg::MODE_ACW;
              st_d.half_period_us = kpsr_pkg::half_period_f(clamped);
              st_d.drive_on       = 1'b1;
            end
          end
          kpsr_pkg::KEY_A: begin
            st_d.run_mode = kpsr_pkg::MODE_STOP;
            st_d.drive_on = 1'b0;
          end
          kpsr_pkg::KEY_C: begin
            st_d.pending_value  = '0;
            st_d.pending_digits = '0;
            st_d.run_mode       = kpsr_pkg::MODE_STOP;
            st_d.drive_on       = 1'b0;
          end
          default: begin
            // B and D do nothing
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= kpsr_pkg::STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

### hw/rtl/keypad_stepper_rate_controller_core.sv
`timescale 1ns / 1ps
// keypad_stepper_rate_controller_core: top level of the keypad stepper controller
// depends on kpsr_pkg, kpsr_if (both channels) and kpsr_ctrl
//
// usage
//   in_i carries one word per key press or timer tick: action selects key or
//   tick, key_code is the keypad code, now_us the tick timestamp in microseconds
//   res_o returns exactly one word per accepted input word, showing the step pin,
//   direction, enable, mode, applied speed, half period, pending entry and the
//   step count as they stand after that word
//   path: an accepted word is registered in the input register and then applied to
//   the state register, whose contents are the result
//   throughput: one word per cycle while results are taken; the input register feeds
//   the state update and the state register doubles as the result register, so a new
//   word enters while the previous result is taken
//   stall: while the result is held, the word in the input register waits and
//   in_i.ready drops once that register is occupied; nothing is lost or repeated
//   reset: rst_ni low clears both valid flags and puts the state at stopped,
//   clockwise, half period 1000 us, empty entry and zero steps

module keypad_stepper_rate_controller_core #(
  parameter int MaxDigits = kpsr_pkg::MAX_DIGITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kpsr_item_if.sink            in_i,
  kpsr_result_if.source        res_o
);

  // input register
  logic        in_vld_q, in_vld_d;
  logic        action_q;
  logic [3:0]  key_q;
  logic [31:0] now_q;

  // result valid, payload lives in the controller state
  logic        res_vld_q, res_vld_d;

  logic        advance;
  logic        in_take;

  kpsr_pkg::kpsr_state_t state;

  // the input word moves into the state once the result slot is free or emptying
  assign advance  = in_vld_q && (!res_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end

    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload register of the input stage
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= in_i.action;
      key_q    <= in_i.key_code;
      now_q    <= in_i.now_us;
    end
  end

  kpsr_ctrl #(
    .MaxDigits (MaxDigits)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .action_i (action_q),
    .key_i    (key_q),
    .now_i    (now_q),
    .state_o  (state)
  );

  assign res_o.valid          = res_vld_q;
  assign res_o.step_level     = state.step_level;
  assign res_o.dir_level      = state.dir_level;
  assign res_o.drive_on       = state.drive_on;
  assign res_o.run_mode       = state.run_mode;
  assign res_o.applied_speed  = state.applied_speed;
  assign res_o.half_period_us = state.half_period_us;
  assign res_o.pending_value  = state.pending_value;
  assign res_o.pending_digits = state.pending_digits;
  assign res_o.steps_taken    = state.steps_taken;

endmodule

### hw/rtl/kpsr_checker.sv
`timescale 1ns / 1ps
// kpsr_checker: port-level assertions on the controller result channel
// depends on kpsr_pkg; bound to keypad_stepper_rate_controller_core

module kpsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        dir_level_i,
  input logic        drive_on_i,
  input logic [1:0]  run_mode_i,
  input logic [10:0] half_period_us_i,
  input logic [31:0] steps_taken_i
);

  logic [31:0] last_steps_q;
  logic [31:0] step_delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_steps_q <= '0;
    end else if (res_valid_i && res_ready_i) begin
      last_steps_q <= steps_taken_i;
    end
  end

  assign step_delta = steps_taken_i - last_steps_q;

  // a held result keeps its step count
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(steps_taken_i))
    else $error("result changed while stalled");

  // enabled exactly when running in some direction
  a_enable_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (drive_on_i == (run_mode_i != kpsr_pkg::MODE_STOP)))
    else $error("enable disagrees with mode");

  // running direction matches the direction pin
  a_dir_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (run_mode_i == kpsr_pkg::MODE_CW || run_mode_i == kpsr_pkg::MODE_ACW)
    |-> (dir_level_i == (run_mode_i == kpsr_pkg::MODE_CW)))
    else $error("direction pin disagrees with mode");

  // one word adds at most one step
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (step_delta == 32'd0 || step_delta == 32'd1))
    else $error("step count jumped");

  // half period stays in its range
  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (half_period_us_i >= 11'd300 && half_period_us_i <= 11'd2000))
    else $error("half period out of range");

endmodule

bind keypad_stepper_rate_controller_core kpsr_checker u_kpsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .dir_level_i      (res_o.dir_level),
  .drive_on_i       (res_o.drive_on),
  .run_mode_i       (res_o.run_mode),
  .half_period_us_i (res_o.half_period_us),
  .steps_taken_i    (res_o.steps_taken)
);
